[hdl/gtg_pkg.sv]
// Package: shared types, codes and constants of the go-to-goal controller.
package gtg_pkg;

    typedef enum logic [2:0] {
        K_TICK   = 3'd0,
        K_START  = 3'd1,
        K_PAUSE  = 3'd2,
        K_RESUME = 3'd3,
        K_STOP   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        M_ROTATE = 2'd0,
        M_TRACK  = 2'd1,
        M_STOP   = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        R_MAX_LIN = 3'd0,
        R_MIN_LIN = 3'd1,
        R_MAX_ANG = 3'd2,
        R_TOL_XY  = 3'd3,
        R_TOL_YAW = 3'd4
    } t_reg;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_DEC  = 12'b000000000010,
        S_M0   = 12'b000000000100,
        S_M1   = 12'b000000001000,
        S_M2   = 12'b000000010000,
        S_ROT  = 12'b000000100000,
        S_CORD = 12'b000001000000,
        S_ERR  = 12'b000010000000,
        S_SQRT = 12'b000100000000,
        S_LIN  = 12'b001000000000,
        S_ANG  = 12'b010000000000,
        S_EMIT = 12'b100000000000
    } t_state;

    localparam logic [14:0] MAX_LIN_RST = 15'd2048;
    localparam logic [15:0] MIN_LIN_RST = 16'hF800;
    localparam logic [14:0] MAX_ANG_RST = 15'd4096;
    localparam logic [14:0] TOL_XY_RST  = 15'd26;
    localparam logic [14:0] TOL_YAW_RST = 15'd1043;

    localparam logic [16:0] ROT_ARM    = 17'd3651;
    localparam logic [16:0] ROT_DONE   = 17'd834;
    localparam logic [16:0] QTR_PI     = 17'd8192;
    localparam logic [16:0] ROT_GAIN   = 17'd38604;
    localparam logic [16:0] TRACK_GAIN = 17'd51472;
    localparam logic [15:0] ROT_LIMIT  = 16'd3277;
    localparam int          CORD_STEPS = 15;

    function automatic logic [13:0] atan_lut(input logic [3:0] i);
        logic [13:0] v;
        case (i)
            4'd0:  v = 14'd8192;
            4'd1:  v = 14'd4836;
            4'd2:  v = 14'd2555;
            4'd3:  v = 14'd1297;
            4'd4:  v = 14'd651;
            4'd5:  v = 14'd326;
            4'd6:  v = 14'd163;
            4'd7:  v = 14'd81;
            4'd8:  v = 14'd41;
            4'd9:  v = 14'd20;
            4'd10: v = 14'd10;
            4'd11: v = 14'd5;
            4'd12: v = 14'd3;
            4'd13: v = 14'd1;
            4'd14: v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] abs16(input logic signed [15:0] v);
        logic signed [16:0] w;
        w = {v[15], v};
        return v[15] ? 17'(-w) : 17'(w);
    endfunction

endpackage

[hdl/go_to_goal_velocity_controller.sv]
// Top level: go-to-goal controller with a shared multiplier and CORDIC sequencer.
// Accept to o_out_valid: pause/stop go straight to emit; a tick goes via the goal check, then at goal,
// rotating or tracking (3 multiply steps, 15 CORDIC steps, up to 8 square-root steps, 2 multiplies).
// Flow: one request at a time; input stalls until the sequencer is idle, and the sequencer
// holds in its emit state while the output is stalled.
// Reset (i_rst_n low, synchronous): registers to defaults, navigation cleared.
module go_to_goal_velocity_controller
    import gtg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_kind,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_heading,
    input  logic signed [15:0] i_goal_x,
    input  logic signed [15:0] i_goal_y,
    input  logic signed [15:0] i_goal_heading,
    input  logic signed [15:0] i_path_heading,
    input  logic               i_path_long,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_linear_cmd,
    output logic signed [15:0] o_angular_cmd,
    output logic               o_at_goal,
    output logic [1:0]         o_mode,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_state r_state, n_state;

    logic [14:0]        r_max_lin, r_max_ang, r_tol_xy, r_tol_yaw;
    logic signed [15:0] r_min_lin;

    logic               r_nav, r_paused, r_need_rot;
    logic signed [15:0] r_rot_tgt, r_sgx, r_sgy, r_sgh;

    logic [2:0]         r_kind;
    logic signed [15:0] r_px, r_py, r_yaw, r_gx, r_gy, r_gh, r_ph;
    logic               r_plong;

    logic signed [16:0] r_dx, r_dy;
    logic [16:0]        r_adx, r_ady, r_ydiff, r_aerr, r_ae;
    logic               r_eneg, r_errneg, r_zero;
    logic [33:0]        r_d2;
    logic signed [33:0] r_x, r_y;
    logic signed [17:0] r_z;
    logic [3:0]         r_cnt;
    logic [8:0]         r_s;
    logic [15:0]        r_lin;

    logic signed [15:0] r_res_lin, r_res_ang;
    logic               r_res_reach;
    logic [1:0]         r_res_mode;

    logic               r_ovalid;
    logic signed [15:0] r_olin, r_oang;
    logic               r_oreach;
    logic [1:0]         r_omode;

    logic [16:0] m_a, m_b;
    logic [33:0] m_p;
    logic [7:0]  trial;
    logic        in_acc, cfg_wr, slot_free;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign slot_free  = !r_ovalid || !i_out_stall;
    assign trial      = r_s[7:0] | (8'd1 << r_cnt[2:0]);

    always_comb begin
        prdata = 32'd0;
        case (t_reg'(paddr[4:2]))
            R_MAX_LIN: prdata = {17'd0, r_max_lin};
            R_MIN_LIN: prdata = {{16{r_min_lin[15]}}, r_min_lin};
            R_MAX_ANG: prdata = {17'd0, r_max_ang};
            R_TOL_XY:  prdata = {17'd0, r_tol_xy};
            R_TOL_YAW: prdata = {17'd0, r_tol_yaw};
            default:   prdata = 32'd0;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        m_a = 17'd0;
        m_b = 17'd0;
        case (r_state)
            S_M0:    begin m_a = r_adx; m_b = r_adx; end
            S_M1:    begin m_a = r_ady; m_b = r_ady; end
            S_M2:    begin m_a = {2'd0, r_tol_xy}; m_b = {2'd0, r_tol_xy}; end
            S_ROT:   begin m_a = r_ae; m_b = ROT_GAIN; end
            S_SQRT:  begin m_a = {9'd0, trial}; m_b = {9'd0, trial}; end
            S_LIN:   begin m_a = {8'd0, r_s}; m_b = {2'd0, r_max_lin}; end
            S_ANG:   begin m_a = r_aerr; m_b = TRACK_GAIN; end
            default: begin m_a = 17'd0; m_b = 17'd0; end
        endcase
    end
    assign m_p = m_a * m_b;

    logic signed [15:0] dec_diff, rot_diff, err16, z16;
    logic signed [33:0] xs, ys;
    logic [16:0]        rnd_m;
    logic [15:0]        lin_raw, mag;
    logic signed [16:0] lin_s;

    always_comb begin
        dec_diff = r_ph - r_yaw;
        rot_diff = r_rot_tgt - r_yaw;
        xs       = r_x >>> r_cnt;
        ys       = r_y >>> r_cnt;
        z16      = r_zero ? 16'sd0 : r_z[15:0];
        err16    = z16 - r_yaw;
        rnd_m    = 17'((m_p + 34'd32768) >> 16);
        lin_raw  = 16'((m_p + 34'd128) >> 8);
        if (r_aerr >= QTR_PI) lin_raw = 16'd0;
        lin_s = {1'b0, lin_raw};
        if (lin_s < $signed({r_min_lin[15], r_min_lin})) lin_s = {r_min_lin[15], r_min_lin};
        if (lin_s > $signed({2'd0, r_max_lin})) lin_s = $signed({2'd0, r_max_lin});
        mag = 16'd0;
        if (r_state == S_ROT) begin
            mag = (rnd_m > {1'b0, ROT_LIMIT}) ? ROT_LIMIT : rnd_m[15:0];
        end else begin
            mag = (rnd_m > {2'd0, r_max_ang}) ? {1'b0, r_max_ang} : rnd_m[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_max_lin  <= MAX_LIN_RST;
            r_min_lin  <= MIN_LIN_RST;
            r_max_ang  <= MAX_ANG_RST;
            r_tol_xy   <= TOL_XY_RST;
            r_tol_yaw  <= TOL_YAW_RST;
            r_nav      <= 1'b0;
            r_paused   <= 1'b0;
            r_need_rot <= 1'b0;
            r_rot_tgt  <= '0;
            r_sgx      <= '0;
            r_sgy      <= '0;
            r_sgh      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (t_reg'(paddr[4:2]))
                    R_MAX_LIN: r_max_lin <= pwdata[14:0];
                    R_MIN_LIN: r_min_lin <= pwdata[15:0];
                    R_MAX_ANG: r_max_ang <= pwdata[14:0];
                    R_TOL_XY:  r_tol_xy  <= pwdata[14:0];
                    R_TOL_YAW: r_tol_yaw <= pwdata[14:0];
                    default: ;
                endcase
            end
            if (r_state == S_EMIT && slot_free) r_ovalid <= 1'b1;
            else if (!i_out_stall)              r_ovalid <= 1'b0;
            case (r_state)
                S_DEC: begin
                    case (t_kind'(r_kind))
                        K_START: begin
                            r_sgx      <= r_gx;
                            r_sgy      <= r_gy;
                            r_sgh      <= r_gh;
                            r_need_rot <= r_plong && (abs16(dec_diff) > ROT_ARM);
                            if (r_plong && abs16(dec_diff) > ROT_ARM) r_rot_tgt <= r_ph;
                            r_nav    <= 1'b1;
                            r_paused <= 1'b0;
                        end
                        K_PAUSE:  r_paused <= 1'b1;
                        K_RESUME: if (r_nav && r_paused) r_paused <= 1'b0;
                        K_STOP: begin
                            r_nav    <= 1'b0;
                            r_paused <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                S_M2: begin
                    if (r_d2 < m_p && r_ydiff < {2'd0, r_tol_yaw}) begin
                        r_nav    <= 1'b0;
                        r_paused <= 1'b0;
                    end else if (r_need_rot && r_ae < ROT_DONE) begin
                        r_need_rot <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind  <= i_kind;
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_yaw   <= i_heading;
            r_gx    <= i_goal_x;
            r_gy    <= i_goal_y;
            r_gh    <= i_goal_heading;
            r_ph    <= i_path_heading;
            r_plong <= i_path_long;
        end
        case (r_state)
            S_DEC: begin
                r_dx      <= 17'(r_sgx) - 17'(r_px);
                r_dy      <= 17'(r_sgy) - 17'(r_py);
                r_adx     <= (17'(r_sgx) < 17'(r_px)) ? 17'(17'(r_px) - 17'(r_sgx))
                                                      : 17'(17'(r_sgx) - 17'(r_px));
                r_ady     <= (17'(r_sgy) < 17'(r_py)) ? 17'(17'(r_py) - 17'(r_sgy))
                                                      : 17'(17'(r_sgy) - 17'(r_py));
                r_ydiff   <= abs16(16'(r_sgh - r_yaw));
                r_ae      <= abs16(rot_diff);
                r_eneg    <= rot_diff[15];
                r_res_lin   <= '0;
                r_res_ang   <= '0;
                r_res_reach <= 1'b0;
                r_res_mode  <= M_STOP;
            end
            S_M0: r_d2 <= m_p;
            S_M1: r_d2 <= r_d2 + m_p;
            S_M2: begin
                r_cnt  <= '0;
                r_zero <= (r_dx == 17'sd0) && (r_dy == 17'sd0);
                if (r_dx < 0) begin
                    r_x <= -(34'(r_dx) <<< 14);
                    r_y <= -(34'(r_dy) <<< 14);
                    r_z <= 18'sd32768;
                end else begin
                    r_x <= 34'(r_dx) <<< 14;
                    r_y <= 34'(r_dy) <<< 14;
                    r_z <= '0;
                end
                r_res_reach <= 1'b1;
            end
            S_ROT: begin
                r_res_lin   <= '0;
                r_res_ang   <= r_eneg ? -$signed(mag) : $signed(mag);
                r_res_reach <= 1'b0;
                r_res_mode  <= M_ROTATE;
            end
            S_CORD: begin
                r_cnt <= r_cnt + 4'd1;
                if (r_y > 0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + $signed({4'd0, atan_lut(r_cnt)});
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - $signed({4'd0, atan_lut(r_cnt)});
                end
            end
            S_ERR: begin
                r_aerr   <= abs16(err16);
                r_errneg <= err16 < 0;
                r_cnt    <= 4'd7;
                r_s      <= (r_d2 >= 34'd65536) ? 9'd256 : 9'd0;
            end
            S_SQRT: begin
                r_cnt <= r_cnt - 4'd1;
                if (m_p <= r_d2) r_s <= {1'b0, trial};
            end
            S_LIN: r_lin <= lin_s[15:0];
            S_ANG: begin
                r_res_lin   <= r_lin;
                r_res_ang   <= r_errneg ? -$signed(mag) : $signed(mag);
                r_res_reach <= 1'b0;
                r_res_mode  <= M_TRACK;
            end
            S_EMIT: begin
                if (slot_free) begin
                    r_olin   <= r_res_lin;
                    r_oang   <= r_res_ang;
                    r_oreach <= r_res_reach;
                    r_omode  <= r_res_mode;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_DEC;
            S_DEC: begin
                case (t_kind'(r_kind))
                    K_PAUSE, K_STOP: n_state = S_EMIT;
                    K_TICK:  n_state = (r_nav && !r_paused) ? S_M0 : S_IDLE;
                    default: n_state = S_IDLE;
                endcase
            end
            S_M0: n_state = S_M1;
            S_M1: n_state = S_M2;
            S_M2: begin
                if (r_d2 < m_p && r_ydiff < {2'd0, r_tol_yaw}) n_state = S_EMIT;
                else if (r_need_rot && r_ae >= ROT_DONE)      n_state = S_ROT;
                else                                          n_state = S_CORD;
            end
            S_ROT:  n_state = S_EMIT;
            S_CORD: if (r_cnt == 4'(CORD_STEPS - 1)) n_state = S_ERR;
            S_ERR:  n_state = (r_d2 >= 34'd65536) ? S_LIN : S_SQRT;
            S_SQRT: if (r_cnt == 4'd0) n_state = S_LIN;
            S_LIN:  n_state = S_ANG;
            S_ANG:  n_state = S_EMIT;
            S_EMIT: if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid    = r_ovalid;
    assign o_linear_cmd   = r_olin;
    assign o_angular_cmd  = r_oang;
    assign o_at_goal      = r_oreach;
    assign o_mode         = r_omode;

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_rot_lin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mode == M_ROTATE) |-> (o_linear_cmd == 16'sd0))
        else $error("rotate command with linear speed");
    a_reach_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_at_goal) |-> (o_mode == M_STOP && o_angular_cmd == 16'sd0))
        else $error("goal reached with motion");
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_EMIT))
        else $error("result outside emit state");
`endif

endmodule
